### sv/yuv_box_outline_overlay_assert.svh
// Assertion macros shared by the overlay RTL.
`ifndef YUV_BOX_OUTLINE_OVERLAY_ASSERT_SVH
`define YUV_BOX_OUTLINE_OVERLAY_ASSERT_SVH

// Implication checked on every rising clock edge, muted while reset is asserted.
`define OVL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every rising clock edge, muted during reset.
`define OVL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/ybo_pkg.sv
// Package with register map, palette tables and widths for the box outline overlay.
`timescale 1ns / 1ps
`default_nettype none

package ybo_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 4096;

    localparam int unsigned COORD_W = 12;
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned SUM_W   = 14;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_BOX_LEFT     = 3'd2,
        REG_BOX_TOP      = 3'd3,
        REG_BOX_WIDTH    = 3'd4,
        REG_BOX_HEIGHT   = 3'd5,
        REG_PALETTE      = 3'd6,
        REG_CHROMA_FMT   = 3'd7
    } reg_index_t;

    localparam logic [3:0] PAL_GREEN = 4'd8;

    typedef logic [7:0]  luma_t;
    typedef logic [15:0] chroma_t;

    localparam luma_t PAL_Y [0:8] = '{
        8'hFF, 8'h00, 8'h6A, 8'hAA, 8'h1D, 8'hE1, 8'hAD, 8'h4C, 8'h95
    };

    localparam chroma_t PAL_UV [0:8] = '{
        16'h8080, 16'h8080, 16'hDECA, 16'h10A6, 16'h6BFF,
        16'h9400, 16'hBA1E, 16'hFF54, 16'h152B
    };

    // Outline hit flags for one axis.
    typedef struct packed {
        logic in_box;
        logic interior;
    } axis_hit_t;

endpackage

`default_nettype wire

### sv/yuv_box_outline_overlay.sv
// Top level of the streaming rectangle outline overlay for NV12 / NV16 frames.
// Pipeline: 3 register stages (position map, compares, output register).
// Throughput: one sample per clock; the pipeline moves whenever the output register is free.
// Stalls on the master side hold every stage; no item is lost or repeated.
// Reset (rst_n, asynchronous, active low) empties the pipeline and loads the register
// defaults: a 1920x1080 frame, an empty box at the origin, green color, NV12 chroma.
`timescale 1ns / 1ps
`default_nettype none

`include "yuv_box_outline_overlay_assert.svh"

module yuv_box_outline_overlay #(
    parameter int unsigned MAX_DIM = ybo_pkg::MAX_DIM_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    // Configuration port.
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ybo_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [ybo_pkg::DATA_W-1:0]  pwdata,
    output logic      [ybo_pkg::DATA_W-1:0]  prdata,
    output logic                             pready,

    // Input samples.
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [39:0]                 s_tdata,   // column[11:0], row[23:12], sample_in[39:24]
    input  wire logic                        s_tuser,   // plane_select[0]

    // Output samples.
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic      [15:0]                 m_tdata,   // sample_out[15:0]
    output logic                             m_tuser    // painted[0]
);

    import ybo_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   frame_width_reg;
    logic [DIM_W-1:0]   frame_height_reg;
    logic [COORD_W-1:0] box_left_reg;
    logic [COORD_W-1:0] box_top_reg;
    logic [DIM_W-1:0]   box_width_reg;
    logic [DIM_W-1:0]   box_height_reg;
    logic [3:0]         palette_index_reg;
    logic               chroma_format_reg;

    logic               cfg_write;
    reg_index_t         cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= DIM_W'(1920);
            frame_height_reg  <= DIM_W'(1080);
            box_left_reg      <= '0;
            box_top_reg       <= '0;
            box_width_reg     <= '0;
            box_height_reg    <= '0;
            palette_index_reg <= PAL_GREEN;
            chroma_format_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg   <= pwdata[DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg  <= pwdata[DIM_W-1:0];
                REG_BOX_LEFT:     box_left_reg      <= pwdata[COORD_W-1:0];
                REG_BOX_TOP:      box_top_reg       <= pwdata[COORD_W-1:0];
                REG_BOX_WIDTH:    box_width_reg     <= pwdata[DIM_W-1:0];
                REG_BOX_HEIGHT:   box_height_reg    <= pwdata[DIM_W-1:0];
                REG_PALETTE:      palette_index_reg <= pwdata[3:0];
                REG_CHROMA_FMT:   chroma_format_reg <= pwdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_reg);
            REG_BOX_LEFT:     prdata = DATA_W'(box_left_reg);
            REG_BOX_TOP:      prdata = DATA_W'(box_top_reg);
            REG_BOX_WIDTH:    prdata = DATA_W'(box_width_reg);
            REG_BOX_HEIGHT:   prdata = DATA_W'(box_height_reg);
            REG_PALETTE:      prdata = DATA_W'(palette_index_reg);
            REG_CHROMA_FMT:   prdata = DATA_W'(chroma_format_reg);
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Box edges derived from the registers. These are recomputed every
    // cycle, so they settle in the cycle after a write, which is before any
    // sample accepted after that write reaches the compare stage.
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] lim_x;
    logic [DIM_W-1:0] lim_y;
    logic [SUM_W-1:0] right_sum;
    logic [SUM_W-1:0] bottom_sum;

    logic [DIM_W-1:0] x1_next, x2_next, y1_next, y2_next;
    logic [DIM_W-1:0] x1_reg,  x2_reg,  y1_reg,  y2_reg;
    logic [SUM_W-1:0] x1p2_reg, y1p2_reg;
    luma_t            color_y_reg;
    chroma_t          color_uv_reg;
    logic [3:0]       pal_sel;

    // The usable frame size saturates at MAX_DIM.
    assign lim_x = (32'(frame_width_reg) > MAX_DIM)  ? DIM_W'(MAX_DIM) : frame_width_reg;
    assign lim_y = (32'(frame_height_reg) > MAX_DIM) ? DIM_W'(MAX_DIM) : frame_height_reg;

    // The edge sums keep their carry, so a box running past the frame clamps
    // instead of wrapping.
    assign right_sum  = SUM_W'(box_left_reg) + SUM_W'(box_width_reg);
    assign bottom_sum = SUM_W'(box_top_reg) + SUM_W'(box_height_reg);

    assign x1_next = (DIM_W'(box_left_reg) > lim_x) ? lim_x : DIM_W'(box_left_reg);
    assign y1_next = (DIM_W'(box_top_reg) > lim_y)  ? lim_y : DIM_W'(box_top_reg);
    assign x2_next = (right_sum > SUM_W'(lim_x))  ? lim_x : right_sum[DIM_W-1:0];
    assign y2_next = (bottom_sum > SUM_W'(lim_y)) ? lim_y : bottom_sum[DIM_W-1:0];

    // Palette codes above the last named color all select green.
    assign pal_sel = (palette_index_reg > PAL_GREEN) ? PAL_GREEN : palette_index_reg;

    always_ff @(posedge clk)
    begin
        x1_reg       <= x1_next;
        x2_reg       <= x2_next;
        y1_reg       <= y1_next;
        y2_reg       <= y2_next;
        x1p2_reg     <= SUM_W'(x1_next) + SUM_W'(2);
        y1p2_reg     <= SUM_W'(y1_next) + SUM_W'(2);
        color_y_reg  <= PAL_Y[pal_sel];
        color_uv_reg <= PAL_UV[pal_sel];
    end

    // ------------------------------------------------------------------
    // Pipeline control. All stages advance together whenever the output
    // register is empty or its transfer completes this cycle.
    // ------------------------------------------------------------------
    logic advance;
    logic v1_reg, v2_reg, v3_reg;

    assign advance  = !v3_reg || m_tready;
    assign s_tready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: map the sample to the co-sited luma position. A chroma pair
    // covers two luma columns; in NV12 it also covers two luma rows.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] in_column;
    logic [COORD_W-1:0] in_row;
    logic [15:0]        in_sample;

    logic [DIM_W-1:0]   lx_next, ly_next;
    logic [DIM_W-1:0]   lx_reg,  ly_reg;
    logic               plane1_reg;
    logic [15:0]        sample1_reg;

    assign in_column = s_tdata[11:0];
    assign in_row    = s_tdata[23:12];
    assign in_sample = s_tdata[39:24];

    assign lx_next = s_tuser ? {in_column, 1'b0} : DIM_W'(in_column);
    assign ly_next = (s_tuser && !chroma_format_reg) ? {in_row, 1'b0} : DIM_W'(in_row);

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lx_reg      <= lx_next;
            ly_reg      <= ly_next;
            plane1_reg  <= s_tuser;
            sample1_reg <= in_sample;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per-axis compares against the box and against the interior
    // shrunk by two. The upper interior bound is tested as pos + 2 < edge,
    // which stays correct when the box is narrower than two pixels.
    // ------------------------------------------------------------------
    axis_hit_t   hx_next, hy_next;
    axis_hit_t   hx_reg,  hy_reg;
    logic        plane2_reg;
    logic [15:0] sample2_reg;

    always_comb
    begin
        hx_next.in_box   = (lx_reg >= x1_reg) && (lx_reg < x2_reg);
        hx_next.interior = (SUM_W'(lx_reg) >= x1p2_reg)
                           && ((SUM_W'(lx_reg) + SUM_W'(2)) < SUM_W'(x2_reg));
        hy_next.in_box   = (ly_reg >= y1_reg) && (ly_reg < y2_reg);
        hy_next.interior = (SUM_W'(ly_reg) >= y1p2_reg)
                           && ((SUM_W'(ly_reg) + SUM_W'(2)) < SUM_W'(y2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hx_reg      <= hx_next;
            hy_reg      <= hy_next;
            plane2_reg  <= plane1_reg;
            sample2_reg <= sample1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: a sample is painted inside the box but outside its interior.
    // Unpainted luma passes its low byte only.
    // ------------------------------------------------------------------
    logic        hit;
    logic [15:0] sample_out_next;
    logic [15:0] sample_out_reg;
    logic        painted_reg;
    logic        plane3_reg;

    assign hit = hx_reg.in_box && hy_reg.in_box && !(hx_reg.interior && hy_reg.interior);

    always_comb
    begin
        if (plane2_reg)
        begin
            sample_out_next = hit ? color_uv_reg : sample2_reg;
        end
        else
        begin
            sample_out_next = {8'h00, (hit ? color_y_reg : sample2_reg[7:0])};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sample_out_reg <= sample_out_next;
            painted_reg    <= hit;
            plane3_reg     <= plane2_reg;
        end
    end

    assign m_tvalid = v3_reg;
    assign m_tdata  = sample_out_reg;
    assign m_tuser  = painted_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    `OVL_ASSERT_NEXT(a_accept_enters_pipe, s_tvalid && s_tready, v1_reg,
        "accepted sample did not enter the first stage")
    `OVL_ASSERT_IMPL(a_luma_upper_zero, m_tvalid && !plane3_reg, m_tdata[15:8] == 8'h00,
        "luma result carries a nonzero upper byte")
    `OVL_ASSERT_NEXT(a_outside_not_painted, advance && v2_reg && !hx_reg.in_box,
        m_tvalid && !m_tuser, "sample outside the box columns was painted")
    `OVL_ASSERT_NEXT(a_interior_not_painted,
        advance && v2_reg && hx_reg.interior && hy_reg.interior,
        m_tvalid && !m_tuser, "sample in the box interior was painted")

endmodule

`default_nettype wire

### dv/tb_yuv_box_outline_overlay.sv
// Self-checking testbench for the YUV box outline overlay.
`timescale 1ns / 1ps

module tb_yuv_box_outline_overlay;

    import ybo_pkg::*;

    // The overlay saturates the frame size to this value.
    localparam int OVL_MAX_DIM = 4096;
    // Pipeline depth quoted at the head of the top level.
    localparam int DUT_LATENCY = 3;
    // Cycles without any transfer on either side before the run is abandoned.
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_PHASES = 16;
    localparam int SAMPLES_PER_PHASE = 90;

    // Outline colors: luma bytes and packed UV pairs (U low byte, V high byte).
    localparam logic [7:0] OUTLINE_Y [0:8] = '{
        8'hFF, 8'h00, 8'h6A, 8'hAA, 8'h1D, 8'hE1, 8'hAD, 8'h4C, 8'h95
    };
    localparam logic [15:0] OUTLINE_UV [0:8] = '{
        16'h8080, 16'h8080, 16'hDECA, 16'h10A6, 16'h6BFF,
        16'h9400, 16'hBA1E, 16'hFF54, 16'h152B
    };

    typedef struct {
        logic [15:0] sample;
        logic        painted;
    } pixel_result_t;

    // Keeps a copy of the overlay registers, predicts every accepted sample and
    // compares the results in order.
    class outline_scoreboard;
        int unsigned   frame_w;
        int unsigned   frame_h;
        int unsigned   left;
        int unsigned   top;
        int unsigned   box_w;
        int unsigned   box_h;
        int unsigned   palette;
        int unsigned   nv16;
        pixel_result_t pending[$];
        int unsigned   errors;

        function new();
            frame_w = 1920;
            frame_h = 1080;
            left    = 0;
            top     = 0;
            box_w   = 0;
            box_h   = 0;
            palette = 8;
            nv16    = 0;
            errors  = 0;
        endfunction

        function void set_reg(reg_index_t idx, int unsigned value);
            case (idx)
                REG_FRAME_WIDTH:  frame_w = value & 32'h1FFF;
                REG_FRAME_HEIGHT: frame_h = value & 32'h1FFF;
                REG_BOX_LEFT:     left    = value & 32'hFFF;
                REG_BOX_TOP:      top     = value & 32'hFFF;
                REG_BOX_WIDTH:    box_w   = value & 32'h1FFF;
                REG_BOX_HEIGHT:   box_h   = value & 32'h1FFF;
                REG_PALETTE:      palette = value & 32'hF;
                default:          nv16    = value & 32'h1;
            endcase
        endfunction

        // Clamp a box edge to the frame, the frame itself saturated to the maximum.
        function int clamp_edge(int unsigned edge_pos, int unsigned lim);
            int unsigned m;
            m = (lim > OVL_MAX_DIM) ? OVL_MAX_DIM : lim;
            return (edge_pos > m) ? m : edge_pos;
        endfunction

        // True when luma pixel (x, y) lies on the two-pixel band of the clamped box.
        function bit on_outline(int x, int y);
            int x1;
            int x2;
            int y1;
            int y2;
            x1 = clamp_edge(left, frame_w);
            x2 = clamp_edge(left + box_w, frame_w);
            y1 = clamp_edge(top, frame_h);
            y2 = clamp_edge(top + box_h, frame_h);
            if (x < x1 || x >= x2 || y < y1 || y >= y2)
                return 1'b0;
            if (x1 + 2 <= x && x < x2 - 2 && y1 + 2 <= y && y < y2 - 2)
                return 1'b0;
            return 1'b1;
        endfunction

        function void note_sample(bit plane, int col, int row, logic [15:0] pix);
            int            pi;
            bit            hit;
            pixel_result_t r;
            pi = (palette > 8) ? 8 : palette;
            if (!plane)
            begin
                hit = on_outline(col, row);
                r.sample = hit ? {8'h00, OUTLINE_Y[pi]} : {8'h00, pix[7:0]};
            end
            else
            begin
                // A chroma pair follows its co-sited luma pixel.
                hit = on_outline(2 * col, (nv16 != 0) ? row : 2 * row);
                r.sample = hit ? OUTLINE_UV[pi] : pix;
            end
            r.painted = hit;
            pending.push_back(r);
        endfunction

        function void check_pixel(logic [15:0] sample, logic painted);
            pixel_result_t want;
            if (pending.size() == 0)
            begin
                $error("sample_out: unexpected result %h (painted %b)", sample, painted);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (sample !== want.sample)
            begin
                $error("sample_out: expected %h, actual %h", want.sample, sample);
                errors++;
            end
            if (painted !== want.painted)
            begin
                $error("painted: expected %b, actual %b", want.painted, painted);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;

    // Configuration port; the APB side idles low.
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [ADDR_W-1:0]   paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Slave side: one sample per transfer.
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [39:0]         s_tdata  = '0;   // column[11:0], row[23:12], sample_in[39:24]
    logic                s_tuser  = 1'b0; // plane_select[0]

    // Master side: one result per transfer.
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [15:0]         m_tdata;         // sample_out[15:0]
    logic                m_tuser;         // painted[0]

    outline_scoreboard   sb;

    yuv_box_outline_overlay #(
        .MAX_DIM (OVL_MAX_DIM)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Reset is asserted once and released on a rising edge.
    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    // One APB write: a setup cycle, then an access cycle that completes on pready.
    // The bus is then left idle before returning, so that back-to-back writes
    // never lower and raise psel in the same time step.
    task automatic write_reg(reg_index_t idx, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Hold the sender until every expected result has come back, then let the
    // pipeline settle.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DUT_LATENCY + 2) @(posedge clk);
    endtask

    // Registers are rewritten only once the overlay has gone idle.
    task automatic load_box(int unsigned fw, int unsigned fh, int unsigned l,
                            int unsigned t, int unsigned w, int unsigned h,
                            int unsigned pal, int unsigned fmt);
        wait_drained();
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_BOX_LEFT, l);
        write_reg(REG_BOX_TOP, t);
        write_reg(REG_BOX_WIDTH, w);
        write_reg(REG_BOX_HEIGHT, h);
        write_reg(REG_PALETTE, pal);
        write_reg(REG_CHROMA_FMT, fmt);
    endtask

    // Present one sample and hold it until the slave side takes the transfer.
    // The valid stays high on return so that a following sample goes out
    // back to back.
    task automatic send_sample(bit plane, int unsigned col, int unsigned row,
                               logic [15:0] pix);
        s_tvalid <= 1'b1;
        s_tuser  <= plane;
        s_tdata  <= {pix, row[11:0], col[11:0]};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(plane, col, row, pix);
    endtask

    task automatic idle_gap(int unsigned cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // A coordinate a few pixels either side of the given position.
    function automatic int unsigned near_pos(int pos);
        int c;
        c = pos - 3 + int'($urandom_range(0, 6));
        if (c < 0)
            c = 0;
        if (c > 4095)
            c = 4095;
        return c;
    endfunction

    // Luma coordinate along one axis, aimed mostly at the box edges and the
    // frame border where the outline decisions change.
    function automatic int unsigned pick_axis(int lo, int hi, int lim);
        int frame_edge;
        frame_edge = (lim > OVL_MAX_DIM) ? OVL_MAX_DIM : lim;
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 4095);
            1:       return near_pos(lo);
            2:       return near_pos(hi);
            3:       return near_pos(frame_edge);
            default: return $urandom_range(0, (hi + 4 > 4095) ? 4095 : hi + 4);
        endcase
    endfunction

    // Frame sizes include the degenerate ones below the legal range and
    // values above the maximum that the overlay saturates.
    function automatic int unsigned rand_frame();
        case ($urandom_range(0, 7))
            0:       return 2;
            1:       return 4096;
            2:       return $urandom_range(4097, 8191);
            3:       return $urandom_range(0, 1);
            4, 5:    return $urandom_range(16, 128);
            default: return $urandom_range(2, 4096);
        endcase
    endfunction

    function automatic int unsigned rand_origin(int unsigned lim);
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 4095;
            2, 3:    return $urandom_range(0, 64);
            4:       return $urandom_range(0, (lim > 4095) ? 4095 : lim);
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    // Box sizes favor thin boxes, where the whole box is painted, and small
    // boxes with a visible interior.
    function automatic int unsigned rand_size();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 6);
            1:       return 4096;
            2, 3:    return $urandom_range(5, 40);
            default: return $urandom_range(0, 4096);
        endcase
    endfunction

    // The receiver repeatedly picks a new stall pattern: always ready,
    // mostly ready, mostly stalled, or a fixed duty cycle. Results are checked
    // on the edge that completes each master-side transfer.
    initial
    begin
        int unsigned cyc;
        int unsigned rx_mode;
        cyc     = 0;
        rx_mode = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_pixel(m_tdata, m_tuser);
            if (cyc % 64 == 0)
                rx_mode = $urandom_range(0, 3);
            cyc++;
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((cyc % 8) < 5);
            endcase
        end
    end

    // Watchdog: the run is abandoned when no transfer happens on either side
    // for too long.
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("yuv_box_outline_overlay: mismatch");
                $finish;
            end
        end
    end

    // Main stimulus: a directed part around fixed boxes, then random phases
    // that each load a new register setting.
    initial
    begin
        int unsigned fw;
        int unsigned fh;
        int unsigned bl;
        int unsigned bt;
        int unsigned bw;
        int unsigned bh;
        int unsigned fmt;
        int unsigned burst;
        int unsigned x;
        int unsigned y;
        bit          plane;

        sb = new();
        wait (rst_n === 1'b1);
        @(posedge clk);

        // Reset values describe an empty box, so nothing is painted.
        send_sample(1'b0, 0, 0, 16'hFF5A);
        send_sample(1'b1, 0, 0, 16'h5AA5);

        // A 16x10 box at (8, 4) in a small frame: corners, both bands of the
        // outline, the interior, just outside, and NV12 chroma co-siting.
        load_box(64, 32, 8, 4, 16, 10, 0, 0);
        send_sample(1'b0, 8, 4, 16'h00AB);
        send_sample(1'b0, 9, 5, 16'h1234);
        send_sample(1'b0, 10, 6, 16'hFFFF);
        send_sample(1'b0, 7, 4, 16'h0042);
        send_sample(1'b0, 23, 13, 16'h0000);
        send_sample(1'b0, 24, 13, 16'hABCD);
        send_sample(1'b0, 22, 8, 16'h7F80);
        send_sample(1'b0, 15, 14, 16'h0011);
        send_sample(1'b1, 4, 2, 16'h1234);
        send_sample(1'b1, 5, 3, 16'hFFFF);
        send_sample(1'b1, 11, 6, 16'h0000);
        // Far corner of both planes lies outside the frame.
        send_sample(1'b0, 4095, 4095, 16'hFFFF);
        send_sample(1'b1, 4095, 4095, 16'hA5A5);

        // Oversized frame saturated to the maximum, box edge sum beyond it,
        // a three-row box that is painted whole, NV16 co-siting.
        load_box(8191, 4096, 4095, 4000, 4096, 3, 15, 1);
        send_sample(1'b0, 4095, 4000, 16'h0101);
        send_sample(1'b0, 4095, 4002, 16'hFEFE);
        send_sample(1'b0, 4095, 4003, 16'h3C3C);
        send_sample(1'b1, 2047, 4001, 16'hC3C3);
        send_sample(1'b0, 4094, 4001, 16'h9999);

        // A zero-width frame paints nothing.
        load_box(0, 1080, 0, 0, 100, 100, 7, 0);
        send_sample(1'b0, 0, 0, 16'h2222);

        // A frame one pixel wide, below the legal range, is used as given.
        load_box(1, 2, 0, 0, 4096, 4096, 5, 1);
        send_sample(1'b0, 0, 0, 16'h3333);
        send_sample(1'b1, 0, 1, 16'h4444);
        send_sample(1'b0, 1, 0, 16'h5555);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
            begin
                // Full-size frame and box.
                fw = 4096; fh = 4096; bl = 0; bt = 0; bw = 4096; bh = 4096;
            end
            else if (ph == 1)
            begin
                // Smallest legal frame with the box pushed off it.
                fw = 2; fh = 2; bl = 4095; bt = 4095; bw = 4096; bh = 4096;
            end
            else
            begin
                fw = rand_frame();
                fh = rand_frame();
                bl = rand_origin(fw);
                bt = rand_origin(fh);
                bw = rand_size();
                bh = rand_size();
            end
            fmt = (ph == 0) ? 1 : $urandom_range(0, 1);
            // Stepping by 5 visits every palette code over sixteen phases.
            load_box(fw, fh, bl, bt, bw, bh, (ph * 5) % 16, fmt);

            burst = 0;
            for (int i = 0; i < SAMPLES_PER_PHASE; i++)
            begin
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 40);
                    if ($urandom_range(0, 2) != 0)
                        idle_gap($urandom_range(1, 12));
                end
                burst--;
                // Once mid-phase, hold off until the pipeline has emptied.
                if (ph == 5 && i == SAMPLES_PER_PHASE / 2)
                    wait_drained();
                plane = $urandom_range(0, 1);
                x = pick_axis(bl, bl + bw, fw);
                y = pick_axis(bt, bt + bh, fh);
                if (plane)
                    send_sample(1'b1, x / 2, (fmt != 0) ? y : y / 2,
                                $urandom_range(0, 65535));
                else
                    send_sample(1'b0, x, y, $urandom_range(0, 65535));
            end
        end

        wait_drained();
        if (sb.errors == 0)
            $display("yuv_box_outline_overlay: match");
        else
            $display("yuv_box_outline_overlay: mismatch");
        $finish;
    end

endmodule
